FILE: design/srpg_pkg.sv
// ----------------------------------------------------------------------------
// srpg_pkg: shared types and constants of the stepper ramp pulse generator
// Field widths, request and result structs, register indexes and the
// acceleration period table.
// ----------------------------------------------------------------------------
`default_nettype none

package srpg_pkg;

	localparam int LEVELS      = 48;
	localparam int LEVEL_BITS  = 6;
	localparam int PERIOD_BITS = 14;
	localparam int STEP_BITS   = 17;
	localparam int ANGLE_BITS  = 16;
	localparam int SPD_BITS    = 16;
	localparam int ACCEL_BITS  = 8;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	// Angle magnitude needs one bit more than the angle for the most negative value
	localparam int MAG_BITS    = ANGLE_BITS + 1;
	localparam int PROD_BITS   = MAG_BITS + SPD_BITS;
	localparam int SCALE_SHIFT = 12;

	// Register reset values
	localparam logic [SPD_BITS-1:0]   SPD_RESET   = 16'd15588;
	localparam logic [ACCEL_BITS-1:0] ACCEL_RESET = 8'd10;
	localparam logic [LEVEL_BITS-1:0] TOP_RESET   = 6'd31;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEPS_PER_DEG = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_PULSES  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TOP_LEVEL     = 2'd2;

	// Request kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef struct packed {
		logic                         kind;
		logic signed [ANGLE_BITS-1:0] move_angle;
	} req_t;

	typedef struct packed {
		logic step_out;
		logic dir_out;
		logic busy_res;
		logic move_done;
	} res_t;

	// Step period in base ticks for each speed level (100 Hz to 4800 Hz at 1 MHz)
	localparam logic [PERIOD_BITS-1:0] PERIOD_TABLE [LEVELS] = '{
		14'd10000, 14'd5000, 14'd3333, 14'd2500, 14'd2000, 14'd1667, 14'd1429, 14'd1250,
		14'd1111,  14'd1000, 14'd909,  14'd833,  14'd769,  14'd714,  14'd667,  14'd625,
		14'd588,   14'd556,  14'd526,  14'd500,  14'd476,  14'd455,  14'd435,  14'd417,
		14'd400,   14'd385,  14'd370,  14'd357,  14'd345,  14'd333,  14'd323,  14'd313,
		14'd303,   14'd294,  14'd286,  14'd278,  14'd270,  14'd263,  14'd256,  14'd250,
		14'd244,   14'd238,  14'd233,  14'd227,  14'd222,  14'd217,  14'd213,  14'd208
	};

	// Period word for a level; levels past the table use the last word
	function automatic logic [PERIOD_BITS-1:0] period_word(input logic [LEVEL_BITS-1:0] lvl);
		logic [LEVEL_BITS-1:0] idx;
		idx = (lvl > LEVEL_BITS'(LEVELS - 1)) ? LEVEL_BITS'(LEVELS - 1) : lvl;
		return PERIOD_TABLE[idx];
	endfunction

endpackage

`default_nettype wire

FILE: design/srpg_rom.sv
// ----------------------------------------------------------------------------
// srpg_rom: period table read port
// Synchronous read of the period table.
// ----------------------------------------------------------------------------
`default_nettype none

module srpg_rom (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [srpg_pkg::LEVEL_BITS-1:0]   addr,
	output logic      [srpg_pkg::PERIOD_BITS-1:0]  data
);

	logic [srpg_pkg::PERIOD_BITS-1:0] data_q;

	// Register the word of the addressed level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= srpg_pkg::PERIOD_TABLE[0];
		end else begin
			data_q <= srpg_pkg::period_word(addr);
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

FILE: design/srpg_core.sv
// ----------------------------------------------------------------------------
// srpg_core: channel state and step sequencing
// Holds the configuration registers and the move state, applies one request
// per cycle when accepted and forms its result. The current step period
// comes from the period table read port, addressed with the next speed level.
// ----------------------------------------------------------------------------
`default_nettype none

module srpg_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [srpg_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  wire logic [srpg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                                req_acc,
	input  wire srpg_pkg::req_t                      req,
	input  wire logic [srpg_pkg::PERIOD_BITS-1:0]    period,
	output logic      [srpg_pkg::LEVEL_BITS-1:0]     rom_addr,
	output srpg_pkg::res_t                           res
);

	localparam int PB = srpg_pkg::PERIOD_BITS;
	localparam int LB = srpg_pkg::LEVEL_BITS;
	localparam int SB = srpg_pkg::STEP_BITS;
	localparam int AB = srpg_pkg::ACCEL_BITS;
	localparam int MB = srpg_pkg::MAG_BITS;
	localparam int XB = srpg_pkg::PROD_BITS;
	localparam int SH = srpg_pkg::SCALE_SHIFT;

	logic [srpg_pkg::SPD_BITS-1:0] spd_q;
	logic [AB-1:0]                 accel_q;
	logic [LB-1:0]                 top_q;

	logic [PB-1:0] pos_q, pos_n;
	logic [SB-1:0] steps_q, steps_n;
	logic [AB-1:0] pulses_q, pulses_n;
	logic [LB-1:0] lvl_q, lvl_n;
	logic          run_q, run_n;
	logic          dir_q, dir_n;

	logic          neg;
	logic [MB-1:0] mag;
	logic [XB-1:0] prod;
	logic          cnt_nz;
	logic [SB-1:0] cnt_sat;
	logic [PB-1:0] half;
	logic          pin;
	logic          period_end;
	logic [AB-1:0] pulses_inc;
	logic [AB-1:0] lim;
	logic [SB-1:0] steps_dec;
	logic          step;
	logic          done;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_q   <= srpg_pkg::SPD_RESET;
			accel_q <= srpg_pkg::ACCEL_RESET;
			top_q   <= srpg_pkg::TOP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				srpg_pkg::CFG_STEPS_PER_DEG: spd_q   <= cfg_data[srpg_pkg::SPD_BITS-1:0];
				srpg_pkg::CFG_ACCEL_PULSES:  accel_q <= cfg_data[AB-1:0];
				srpg_pkg::CFG_TOP_LEVEL:     top_q   <= cfg_data[LB-1:0];
				default: ;
			endcase
		end
	end

	// Scale the angle magnitude into a step count
	always_comb begin
		neg     = req.move_angle[srpg_pkg::ANGLE_BITS-1];
		mag     = neg ? ({1'b1, {(MB-1){1'b0}}} - {1'b0, req.move_angle})
		              : {1'b0, req.move_angle};
		prod    = XB'(mag) * XB'(spd_q);
		cnt_nz  = |prod[XB-1:SH];
		cnt_sat = (|prod[XB-1:SH+SB]) ? {SB{1'b1}} : prod[SH+SB-1:SH];
	end

	// Next state and result of the request
	always_comb begin
		half       = period >> 1;
		pin        = run_q && (pos_q < half);
		period_end = ({1'b0, pos_q} + (PB+1)'(1)) >= {1'b0, period};
		pulses_inc = pulses_q + AB'(1);
		lim        = (accel_q == '0) ? AB'(1) : accel_q;
		steps_dec  = (steps_q != '0) ? steps_q - SB'(1) : '0;

		pos_n    = pos_q;
		steps_n  = steps_q;
		pulses_n = pulses_q;
		lvl_n    = lvl_q;
		run_n    = run_q;
		dir_n    = dir_q;
		step     = 1'b0;
		done     = 1'b0;

		if (req_acc) begin
			if (req.kind == srpg_pkg::KIND_START) begin
				// Load a move; a zero count leaves everything alone
				if (cnt_nz) begin
					dir_n   = !neg;
					steps_n = cnt_sat;
					if (!run_q) begin
						run_n    = 1'b1;
						pos_n    = '0;
						pulses_n = '0;
						lvl_n    = '0;
					end
				end
				step = run_n && (pos_n < half);
			end else if (run_q) begin
				// Advance one tick; close the step period at its end
				step = pin;
				if (period_end) begin
					if (lvl_q < top_q) begin
						if (pulses_inc >= lim) begin
							pulses_n = '0;
							lvl_n    = lvl_q + LB'(1);
						end else begin
							pulses_n = pulses_inc;
						end
					end
					steps_n = steps_dec;
					pos_n   = '0;
					if (steps_dec == '0) begin
						run_n    = 1'b0;
						done     = 1'b1;
						pulses_n = '0;
						lvl_n    = '0;
					end
				end else begin
					pos_n = pos_q + PB'(1);
				end
			end
		end

		rom_addr      = lvl_n;
		res.step_out  = step;
		res.dir_out   = dir_n;
		res.busy_res  = run_n;
		res.move_done = done;
	end

	// Move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			steps_q  <= '0;
			pulses_q <= '0;
			lvl_q    <= '0;
			run_q    <= 1'b0;
			dir_q    <= 1'b0;
		end else begin
			pos_q    <= pos_n;
			steps_q  <= steps_n;
			pulses_q <= pulses_n;
			lvl_q    <= lvl_n;
			run_q    <= run_n;
			dir_q    <= dir_n;
		end
	end

	// A running move always has steps left
	assert property (@(posedge clk) disable iff (!arst_n) run_q |-> steps_q != '0)
		else $error("running with no steps left");

	// An idle channel sits at the bottom of the ramp
	assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> (lvl_q == '0 && pulses_q == '0))
		else $error("idle channel not at level zero");

	// The table read port tracks the current level
	assert property (@(posedge clk) disable iff (!arst_n)
		period == srpg_pkg::period_word(lvl_q))
		else $error("period word out of step with level");

	// A finished move leaves the channel idle
	assert property (@(posedge clk) disable iff (!arst_n) (req_acc && done) |=> !run_q)
		else $error("channel still running after move done");

	// The tick position stays inside a nonzero period
	assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && period != '0) |-> pos_q < period)
		else $error("tick position past end of period");

endmodule

`default_nettype wire

FILE: design/srpg_obuf.sv
// ----------------------------------------------------------------------------
// srpg_obuf: result output buffer
// Output register plus one skid entry, so a new request can be taken
// while a finished result waits on a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module srpg_obuf (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire srpg_pkg::res_t  push_data,
	output logic                 full,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output srpg_pkg::res_t       out_data
);

	logic           ov_q;
	logic           sv_q;
	srpg_pkg::res_t od_q;
	srpg_pkg::res_t sd_q;
	logic           pop;

	assign pop = ov_q && !out_stall;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (sv_q) begin
			if (pop) begin
				sv_q <= 1'b0;
			end
		end else if (push) begin
			if (ov_q && !pop) begin
				sv_q <= 1'b1;
			end else begin
				ov_q <= 1'b1;
			end
		end else if (pop) begin
			ov_q <= 1'b0;
		end
	end

	// Result data: refill the output from the skid entry first
	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (pop) begin
				od_q <= sd_q;
			end
		end else if (push) begin
			if (ov_q && !pop) begin
				sd_q <= push_data;
			end else begin
				od_q <= push_data;
			end
		end
	end

	assign full      = sv_q;
	assign out_valid = ov_q;
	assign out_data  = od_q;

endmodule

`default_nettype wire

FILE: design/stepper_ramp_pulse_generator.sv
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator: one stepper channel with an acceleration ramp
// Turns start and tick requests into step, direction, busy and done levels.
// ----------------------------------------------------------------------------
// Every request, start or tick, yields one result; the block accepts a
// request every cycle while in_stall is low, and the result is registered
// in the output buffer. The step period is read from a registered period
// table, addressed with the level the request leaves behind, so the next
// request finds its word ready. A two-entry output buffer holds results
// while out_stall is high; in_stall rises only when both entries are full.
// Configuration writes take effect at once and must be done while idle.
`default_nettype none

module stepper_ramp_pulse_generator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire srpg_pkg::req_t                      in_data,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output srpg_pkg::res_t                           out_data,
	input  wire logic                                cfg_we,
	input  wire logic [srpg_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  wire logic [srpg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	logic                             req_acc;
	logic                             buf_full;
	logic [srpg_pkg::LEVEL_BITS-1:0]  rom_addr;
	logic [srpg_pkg::PERIOD_BITS-1:0] period;
	srpg_pkg::res_t                   res;

	// Take a request when the buffer has room
	assign in_stall = buf_full;
	assign req_acc  = in_valid && !buf_full;

	srpg_rom u_rom (
		.clk    (clk),
		.arst_n (arst_n),
		.addr   (rom_addr),
		.data   (period)
	);

	srpg_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req_acc  (req_acc),
		.req      (in_data),
		.period   (period),
		.rom_addr (rom_addr),
		.res      (res)
	);

	srpg_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (req_acc),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
